// ===== rtl/nfa_word_acceptor_top_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the NFA word acceptor
// ----------------------------------------------------------------------------
`ifndef NFA_WORD_ACCEPTOR_TOP_DEFINES_SVH
`define NFA_WORD_ACCEPTOR_TOP_DEFINES_SVH

// same-cycle implication
`define NFA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NFA_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/nfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_pkg
// Shared types, codes and defaults of the NFA word acceptor.
// ----------------------------------------------------------------------------
package nfa_pkg;

    localparam int MAX_STATES_DEF    = 16;
    localparam int ALPHABET_SIZE_DEF = 26;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_STATES  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STATE = 2'd1;

    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_FINAL = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;
    localparam logic [1:0] OP_FEED  = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic [3:0] from_state;
        logic [3:0] to_state;
        logic [4:0] symbol;
    } in_word_t;

    typedef struct packed {
        logic        accepted;
        logic [15:0] active_set;
    } out_word_t;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic add_wr;
        logic final_set;
        logic start_load;
        logic feed_init;
        logic feed_step;
        logic feed_commit;
        logic feed_empty;
        logic result_load;
    } nfa_cmd_t;

    typedef struct packed {
        logic       clr_last;
        logic       feed_last;
        logic       out_free;
        logic       add_ok;
        logic       sym_ok;
        logic [1:0] op;
    } nfa_stat_t;

endpackage

// ===== rtl/nfa_word_acceptor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_word_acceptor_top
// NFA word acceptor: builds an automaton word by word and tracks the active
// state set of the current input string.
//
// Channels: item (valid/stall in), result (valid/stall out), cfg write
// (valid/ready, always ready). Every item word gives one result word.
// Steps: an add transition issues its table read in decode, then merges and
// writes; final and start words act in decode; a fed letter walks its states
// and then commits. A dropped add (state out of use or letter outside the
// alphabet) writes nothing; a fed letter outside the alphabet empties the
// active set. A fed letter walks the transition table one state per cycle
// through its single read port. The result word is registered and appears
// the cycle after its load in the finish state. Reset: the transition table
// is swept to zero, one entry a cycle, over all MAX_STATES * ALPHABET_SIZE
// entries (416 by default); item is stalled during the sweep, cfg writes are
// taken. Final and active sets clear at once. A stalled result is held in its
// register; the next item is processed and waits at its end until it is free.
// ----------------------------------------------------------------------------
module nfa_word_acceptor_top
    import nfa_pkg::*;
#(
    parameter int MAX_STATES    = MAX_STATES_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_stall,
    input  in_word_t              item,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_word_t             result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

`include "nfa_word_acceptor_top_defines.svh"

    nfa_cmd_t  cmd;
    nfa_stat_t stat;
    logic      cfg_we;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    nfa_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .stat       (stat),
        .cmd        (cmd)
    );

    nfa_dp
    #(
        .MAX_STATES    (MAX_STATES),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    )
    u_dp
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item         (item),
        .cmd          (cmd),
        .stat         (stat),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    `NFA_ASSERT_IMP(a_load_free, clk, rst_n, cmd.result_load, stat.out_free, "result overwritten")
    `NFA_ASSERT_IMP(a_clear_stall, clk, rst_n, cmd.clr_step, item_stall, "item taken in clear")
    `NFA_ASSERT_NXT(a_one_word, clk, rst_n, item_valid && !item_stall, item_stall, "word overlap")

endmodule

// ===== rtl/nfa_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_ctrl
// Sequencer: table clear after reset, word decode, table update and the
// per-state walk of a fed letter.
// ----------------------------------------------------------------------------
module nfa_ctrl
    import nfa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  nfa_stat_t stat,
    output nfa_cmd_t  cmd
);

    localparam logic [2:0] ST_CLEAR     = 3'd0;
    localparam logic [2:0] ST_IDLE      = 3'd1;
    localparam logic [2:0] ST_DECODE    = 3'd2;
    localparam logic [2:0] ST_ADD_WR    = 3'd3;
    localparam logic [2:0] ST_FEED      = 3'd4;
    localparam logic [2:0] ST_FEED_TAIL = 3'd5;
    localparam logic [2:0] ST_FINISH    = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign item_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                case (stat.op)
                    OP_ADD:
                    begin
                        // table read is issued here; a valid add merges and writes next cycle
                        state_next = stat.add_ok ? ST_ADD_WR : ST_FINISH;
                    end
                    OP_FINAL:
                    begin
                        cmd.final_set = 1'b1;
                        state_next    = ST_FINISH;
                    end
                    OP_START:
                    begin
                        cmd.start_load = 1'b1;
                        state_next     = ST_FINISH;
                    end
                    OP_FEED:
                    begin
                        if (stat.sym_ok)
                        begin
                            cmd.feed_init = 1'b1;
                            state_next    = ST_FEED;
                        end
                        else
                        begin
                            cmd.feed_empty = 1'b1;
                            state_next     = ST_FINISH;
                        end
                    end
                    default:
                    begin
                        state_next = ST_FINISH;
                    end
                endcase
            end
            ST_ADD_WR:
            begin
                cmd.add_wr = 1'b1;
                state_next = ST_FINISH;
            end
            ST_FEED:
            begin
                cmd.feed_step = 1'b1;
                if (stat.feed_last)
                begin
                    state_next = ST_FEED_TAIL;
                end
            end
            ST_FEED_TAIL:
            begin
                cmd.feed_commit = 1'b1;
                state_next      = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/nfa_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfa_dp
// Datapath: transition table memory, final and active sets, config
// registers and the result word register.
// ----------------------------------------------------------------------------
module nfa_dp
    import nfa_pkg::*;
#(
    parameter int MAX_STATES    = MAX_STATES_DEF,
    parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  in_word_t              item,
    input  nfa_cmd_t              cmd,
    output nfa_stat_t             stat,
    output logic                  result_valid,
    input  logic                  result_stall,
    output out_word_t             result
);

    localparam int DEPTH  = MAX_STATES * ALPHABET_SIZE;
    localparam int AW     = $clog2(DEPTH);
    localparam int SW     = $clog2(MAX_STATES);
    localparam int NW     = $clog2(MAX_STATES + 1);
    localparam int NS_RST = (16 > MAX_STATES) ? MAX_STATES : 16;
    localparam logic [MAX_STATES-1:0] ONE = {{(MAX_STATES-1){1'b0}}, 1'b1};

    logic [MAX_STATES-1:0] mem [DEPTH];

    logic [NW-1:0]         num_states_reg,  num_states_next;
    logic [3:0]            start_state_reg, start_state_next;
    logic [MAX_STATES-1:0] final_reg,       final_next;
    logic [MAX_STATES-1:0] active_reg,      active_next;
    logic [AW-1:0]         clr_addr_reg,    clr_addr_next;
    logic                  pend_reg,        pend_next;
    logic                  result_valid_reg, result_valid_next;
    in_word_t              word_reg,        word_next;
    logic [MAX_STATES-1:0] acc_reg,         acc_next;
    logic [SW-1:0]         cnt_reg,         cnt_next;
    logic [SW-1:0]         pend_state_reg,  pend_state_next;
    logic [AW-1:0]         feed_addr_reg,   feed_addr_next;
    out_word_t             result_reg,      result_next;
    logic [MAX_STATES-1:0] rd_data_reg;

    logic [NW-1:0]          ns_clamped;
    logic [MAX_STATES-1:0]  in_use;
    logic [MAX_STATES-1:0]  acc_sum;
    logic [MAX_STATES-1:0]  start_mask;
    logic [MAX_STATES+15:0] active_ext;
    logic [AW-1:0]          add_addr;
    logic [AW-1:0]          mem_raddr;
    logic [AW-1:0]          mem_waddr;
    logic [MAX_STATES-1:0]  mem_wdata;
    logic                   mem_we;
    logic                   from_ok;
    logic                   to_ok;

    // config: num_states clamps into 1..MAX_STATES
    always_comb
    begin
        if (cfg_data == '0)
        begin
            ns_clamped = NW'(1);
        end
        else if (32'(cfg_data) > MAX_STATES)
        begin
            ns_clamped = NW'(MAX_STATES);
        end
        else
        begin
            ns_clamped = NW'(cfg_data);
        end
    end

    always_comb
    begin
        num_states_next  = num_states_reg;
        start_state_next = start_state_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_NUM_STATES:  num_states_next  = ns_clamped;
                CFG_START_STATE: start_state_next = cfg_data[3:0];
                default:         num_states_next  = num_states_reg;
            endcase
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_STATES; i++)
        begin
            in_use[i] = (i < int'(num_states_reg));
        end
    end

    assign from_ok  = 32'(word_reg.from_state) < 32'(num_states_reg);
    assign to_ok    = 32'(word_reg.to_state) < 32'(num_states_reg);
    assign add_addr = AW'(32'(word_reg.from_state) * ALPHABET_SIZE + 32'(word_reg.symbol));

    assign stat.clr_last  = (clr_addr_reg == AW'(DEPTH - 1));
    assign stat.feed_last = ((NW'(cnt_reg) + NW'(1)) == num_states_reg);
    assign stat.out_free  = !result_valid_reg || !result_stall;
    assign stat.sym_ok    = 32'(word_reg.symbol) < ALPHABET_SIZE;
    assign stat.add_ok    = from_ok && to_ok && stat.sym_ok;
    assign stat.op        = word_reg.op;

    // table port: clear pass and add-merge share the write side
    assign mem_raddr = cmd.feed_step ? feed_addr_reg : add_addr;
    assign mem_we    = cmd.clr_step || cmd.add_wr;
    assign mem_waddr = cmd.clr_step ? clr_addr_reg : add_addr;
    assign mem_wdata = cmd.clr_step ? '0 : (rd_data_reg | (ONE << word_reg.to_state));

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    // read data is registered and lands the cycle after its step
    assign acc_sum = acc_reg |
        ((pend_reg && active_reg[pend_state_reg]) ? rd_data_reg : '0);

    assign start_mask = (32'(start_state_reg) < 32'(num_states_reg)) ?
                        (ONE << start_state_reg) : '0;

    always_comb
    begin
        word_next       = cmd.capture ? item : word_reg;
        clr_addr_next   = cmd.clr_step ? (clr_addr_reg + AW'(1)) : clr_addr_reg;
        pend_next       = cmd.feed_step;
        pend_state_next = cnt_reg;
        acc_next        = cmd.feed_init ? '0 : acc_sum;
        cnt_next        = cnt_reg;
        feed_addr_next  = feed_addr_reg;
        if (cmd.feed_init)
        begin
            cnt_next       = '0;
            feed_addr_next = AW'(word_reg.symbol);
        end
        else if (cmd.feed_step)
        begin
            cnt_next       = cnt_reg + SW'(1);
            feed_addr_next = feed_addr_reg + AW'(ALPHABET_SIZE);
        end

        final_next = final_reg;
        if (cmd.final_set && from_ok)
        begin
            final_next = final_reg | (ONE << word_reg.from_state);
        end

        active_next = active_reg;
        if (cmd.start_load)
        begin
            active_next = start_mask;
        end
        else if (cmd.feed_empty)
        begin
            active_next = '0;
        end
        else if (cmd.feed_commit)
        begin
            active_next = acc_sum & in_use;
        end
    end

    assign active_ext = {16'b0, active_reg};

    always_comb
    begin
        result_next = result_reg;
        if (cmd.result_load)
        begin
            result_next.accepted   = |(active_reg & final_reg & in_use);
            result_next.active_set = active_ext[15:0];
        end
        if (cmd.result_load)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
        else
        begin
            result_valid_next = result_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_states_reg   <= NW'(NS_RST);
            start_state_reg  <= '0;
            final_reg        <= '0;
            active_reg       <= '0;
            clr_addr_reg     <= '0;
            pend_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            num_states_reg   <= num_states_next;
            start_state_reg  <= start_state_next;
            final_reg        <= final_next;
            active_reg       <= active_next;
            clr_addr_reg     <= clr_addr_next;
            pend_reg         <= pend_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg       <= word_next;
        acc_reg        <= acc_next;
        cnt_reg        <= cnt_next;
        pend_state_reg <= pend_state_next;
        feed_addr_reg  <= feed_addr_next;
        result_reg     <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule
